### hw/rtl/assert_macros.svh
// Assertion macros shared by the release scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ptrs_pkg.sv
// Shared constants, codes and types of the periodic task release scheduler.
`default_nettype none

package ptrs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_NUM_TASKS = 4;
    localparam int DEF_TIME_BITS = 32;

    // Fixed field widths.
    localparam int PHASE_W    = 16;
    localparam int MISS_W     = 16;
    localparam int EXEC_W     = 32;
    localparam int TOTAL_W    = 48;
    localparam int COUNT_W    = 32;
    localparam int MASK_W     = 4;
    localparam int IDX_W      = 2;
    localparam int OP_W       = 2;
    localparam int TASKS_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 176;

    // Reset values of the configuration registers.
    localparam logic [PHASE_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [TASKS_W-1:0] TASKS_RESET  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0 = 3'd2;

    // Event kinds.
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // Per-slot commands, asserted only in the cycle a request is processed.
    typedef struct packed {
        logic tick;
        logic start;
        logic finish;
    } slot_ctrl_t;

    // Per-slot statistics as they stand after the current request.
    typedef struct packed {
        logic               running;
        logic [MISS_W-1:0]  miss_count;
        logic [EXEC_W-1:0]  min_exec;
        logic [EXEC_W-1:0]  max_exec;
        logic [TOTAL_W-1:0] total_exec;
        logic [COUNT_W-1:0] exec_count;
    } slot_stats_t;

endpackage

`default_nettype wire

### hw/rtl/ptrs_slot.sv
// One task slot: phase counter, running flag, miss counter and execution statistics.
`default_nettype none

module ptrs_slot #(
    parameter int TIME_BITS = ptrs_pkg::DEF_TIME_BITS
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  ptrs_pkg::slot_ctrl_t              ctrl,
    input  wire  [ptrs_pkg::PHASE_W-1:0]      period,
    input  wire  [TIME_BITS-1:0]              exec_time,
    output logic                              release_pulse,
    output logic                              miss_pulse,
    output ptrs_pkg::slot_stats_t             stats_next
);

    `include "assert_macros.svh"

    logic [ptrs_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         running_reg, running_next;
    logic [ptrs_pkg::MISS_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic [TIME_BITS-1:0]         min_reg, min_next;
    logic [TIME_BITS-1:0]         max_reg, max_next;
    logic [ptrs_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [ptrs_pkg::COUNT_W-1:0] count_reg, count_next;

    logic [ptrs_pkg::PHASE_W:0]   phase_inc;
    logic                         wrap;
    logic [ptrs_pkg::TOTAL_W:0]   total_sum;

    // Phase wraps once the incremented count reaches the period; a zero period wraps every tick.
    assign phase_inc = {1'b0, phase_reg} + {{ptrs_pkg::PHASE_W{1'b0}}, 1'b1};
    assign wrap      = phase_inc >= {1'b0, period};
    assign total_sum = {1'b0, total_reg} + (ptrs_pkg::TOTAL_W + 1)'(exec_time);

    assign release_pulse = ctrl.tick && wrap && !running_reg;
    assign miss_pulse    = ctrl.tick && wrap && running_reg;

    // Next-state logic for tick, start and finish.
    always_comb begin
        phase_next    = phase_reg;
        running_next  = running_reg;
        miss_cnt_next = miss_cnt_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        total_next    = total_reg;
        count_next    = count_reg;
        if (ctrl.tick) begin
            phase_next = wrap ? '0 : phase_inc[ptrs_pkg::PHASE_W-1:0];
            if (miss_pulse && (miss_cnt_reg != '1)) begin
                miss_cnt_next = miss_cnt_reg + ptrs_pkg::MISS_W'(1);
            end
        end
        if (ctrl.start) begin
            running_next = 1'b1;
        end
        if (ctrl.finish) begin
            running_next = 1'b0;
            // The stored minimum is meaningless until the first finish.
            if ((count_reg == '0) || (exec_time < min_reg)) begin
                min_next = exec_time;
            end
            if (exec_time > max_reg) begin
                max_next = exec_time;
            end
            total_next = total_sum[ptrs_pkg::TOTAL_W] ? '1 : total_sum[ptrs_pkg::TOTAL_W-1:0];
            if (count_reg != '1) begin
                count_next = count_reg + ptrs_pkg::COUNT_W'(1);
            end
        end
    end

    // Statistics after this request; minimum reads all ones before any finish.
    always_comb begin
        stats_next.running    = running_next;
        stats_next.miss_count = miss_cnt_next;
        stats_next.min_exec   = (count_next == '0) ? '1 : ptrs_pkg::EXEC_W'(min_next);
        stats_next.max_exec   = ptrs_pkg::EXEC_W'(max_next);
        stats_next.total_exec = total_next;
        stats_next.exec_count = count_next;
    end

    // Control and statistic registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            running_reg  <= 1'b0;
            miss_cnt_reg <= '0;
            max_reg      <= '0;
            total_reg    <= '0;
            count_reg    <= '0;
        end else begin
            phase_reg    <= phase_next;
            running_reg  <= running_next;
            miss_cnt_reg <= miss_cnt_next;
            max_reg      <= max_next;
            total_reg    <= total_next;
            count_reg    <= count_next;
        end
    end

    // The minimum needs no reset: it is only read once the count is nonzero.
    always_ff @(posedge aclk) begin
        min_reg <= min_next;
    end

    // Saturating counters never move backward.
    `ASSERT_NEXT(a_miss_monotonic, aclk, aresetn, 1'b1,
        miss_cnt_reg >= $past(miss_cnt_reg), "miss counter decreased")
    `ASSERT_NEXT(a_count_monotonic, aclk, aresetn, 1'b1,
        count_reg >= $past(count_reg), "execution count decreased")
    `ASSERT_NEXT(a_total_monotonic, aclk, aresetn, 1'b1,
        total_reg >= $past(total_reg), "execution total decreased")

endmodule

`default_nettype wire

### hw/rtl/periodic_task_release_scheduler_top.sv
// Top level of the periodic task release scheduler: stream ports, configuration and readout.
//
// Channel  Direction  Handshake                Contents
// s_       in         s_tvalid / s_tready      tuser: opcode; tdata: task_index, exec_time
// m_       out        m_tvalid / m_tready      tdata: masks and selected task statistics
// cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data (register write)
//
// One request per cycle is sustained while the output register is drained; a request passes
// through the input register, where it is evaluated against the slot state, and its result
// is loaded into the output register on the edge at which it leaves the input register.
// When the output register is full and not taken, the input register holds its request.
// aresetn is synchronous and active low; configuration writes are accepted every cycle.
`default_nettype none

module periodic_task_release_scheduler_top #(
    parameter int NUM_TASKS = ptrs_pkg::DEF_NUM_TASKS,
    parameter int TIME_BITS = ptrs_pkg::DEF_TIME_BITS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // Request stream
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [ptrs_pkg::S_TDATA_W-1:0]      s_tdata,   // task_index, exec_time
    input  wire  [ptrs_pkg::S_TUSER_W-1:0]      s_tuser,   // opcode
    // Result stream
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // release_mask, miss_mask, sel_running, sel_miss_count, sel_min_exec,
    // sel_max_exec, sel_total_exec, sel_exec_count
    output logic [ptrs_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration writes
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ptrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [ptrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    `include "assert_macros.svh"

    // Configuration registers.
    logic                           enable_reg;
    logic [ptrs_pkg::TASKS_W-1:0]   tasks_reg;
    logic [ptrs_pkg::PHASE_W-1:0]   period_reg [NUM_TASKS];

    // Input stage.
    logic                           in_valid_reg;
    ptrs_pkg::opcode_t              in_op_reg;
    logic [ptrs_pkg::IDX_W-1:0]     in_idx_reg;
    logic [TIME_BITS-1:0]           in_time_reg;

    // Output stage.
    logic                           out_valid_reg;
    logic [ptrs_pkg::MASK_W-1:0]    release_mask_reg;
    logic [ptrs_pkg::MASK_W-1:0]    miss_mask_reg;
    ptrs_pkg::slot_stats_t          sel_stats_reg;

    logic                           advance;
    logic [NUM_TASKS-1:0]           release_vec;
    logic [NUM_TASKS-1:0]           miss_vec;
    ptrs_pkg::slot_stats_t          slot_stats [NUM_TASKS];
    ptrs_pkg::slot_stats_t          sel_stats;

    // The input stage moves on when the output register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            tasks_reg  <= ptrs_pkg::TASKS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == ptrs_pkg::CFG_ENABLE) begin
                enable_reg <= cfg_data[0];
            end
            if (cfg_index == ptrs_pkg::CFG_TASKS) begin
                tasks_reg <= cfg_data[ptrs_pkg::TASKS_W-1:0];
            end
        end
    end

    // Period registers, one per task.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (!aresetn) begin
                period_reg[i] <= ptrs_pkg::PERIOD_RESET;
            end else if (cfg_valid &&
                         (cfg_index == ptrs_pkg::CFG_PERIOD0 + ptrs_pkg::CFG_IDX_W'(i))) begin
                period_reg[i] <= cfg_data;
            end
        end
    end

    // One slot per task.
    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_slot
        ptrs_pkg::slot_ctrl_t ctrl;
        logic                 hit;

        assign hit = in_idx_reg == ptrs_pkg::IDX_W'(i);

        // Slots beyond the configured count hold their phase on ticks.
        always_comb begin
            ctrl.tick   = advance && (in_op_reg == ptrs_pkg::OP_TICK) && enable_reg &&
                          (ptrs_pkg::TASKS_W'(i) < tasks_reg);
            ctrl.start  = advance && (in_op_reg == ptrs_pkg::OP_START) && hit;
            ctrl.finish = advance && (in_op_reg == ptrs_pkg::OP_FINISH) && hit;
        end

        ptrs_slot #(
            .TIME_BITS (TIME_BITS)
        ) u_slot (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .period        (period_reg[i]),
            .exec_time     (in_time_reg),
            .release_pulse (release_vec[i]),
            .miss_pulse    (miss_vec[i]),
            .stats_next    (slot_stats[i])
        );
    end

    // Readout of the selected slot; an index with no slot reads as zero.
    always_comb begin
        sel_stats = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (in_idx_reg == ptrs_pkg::IDX_W'(i)) begin
                sel_stats = slot_stats[i];
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= ptrs_pkg::opcode_t'(s_tuser[ptrs_pkg::OP_W-1:0]);
            in_idx_reg  <= s_tdata[ptrs_pkg::IDX_W-1:0];
            in_time_reg <= s_tdata[ptrs_pkg::IDX_W +: TIME_BITS];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            release_mask_reg <= ptrs_pkg::MASK_W'(release_vec);
            miss_mask_reg    <= ptrs_pkg::MASK_W'(miss_vec);
            sel_stats_reg    <= sel_stats;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       sel_stats_reg.exec_count,
                       sel_stats_reg.total_exec,
                       sel_stats_reg.max_exec,
                       sel_stats_reg.min_exec,
                       sel_stats_reg.miss_count,
                       sel_stats_reg.running,
                       miss_mask_reg,
                       release_mask_reg};

    // A task is either released or late on a tick, never both.
    `ASSERT_IMPL(a_masks_disjoint, aclk, aresetn, out_valid_reg,
        (release_mask_reg & miss_mask_reg) == '0, "release and miss set for one task")
    // A result appears only when the input stage hands one over.
    `ASSERT_NEXT(a_no_spurious_result, aclk, aresetn, !out_valid_reg && !advance,
        !out_valid_reg, "result appeared without a request")
    // A blocked request stays in the input register unchanged.
    `ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(in_time_reg) && $stable(in_idx_reg),
        "blocked request was lost or changed")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking stream testbench for the periodic task release scheduler.
`timescale 1ns / 1ps

module tb;

    // Expected result of one request, packed in the order of the result stream.
    typedef struct packed {
        logic [ptrs_pkg::COUNT_W-1:0] exec_count;
        logic [ptrs_pkg::TOTAL_W-1:0] total_exec;
        logic [ptrs_pkg::EXEC_W-1:0]  max_exec;
        logic [ptrs_pkg::EXEC_W-1:0]  min_exec;
        logic [ptrs_pkg::MISS_W-1:0]  miss_count;
        logic                         running;
        logic [ptrs_pkg::MASK_W-1:0]  miss_mask;
        logic [ptrs_pkg::MASK_W-1:0]  release_mask;
    } sched_result_t;

    localparam int RESULT_W = $bits(sched_result_t);

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ptrs_pkg::S_TDATA_W-1:0]  s_tdata;   // task_index, exec_time
    logic [ptrs_pkg::S_TUSER_W-1:0]  s_tuser;   // opcode
    logic                            m_tvalid;
    logic                            m_tready;
    // release_mask, miss_mask, sel_running, sel_miss_count, sel_min_exec,
    // sel_max_exec, sel_total_exec, sel_exec_count
    logic [ptrs_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [ptrs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ptrs_pkg::CFG_DATA_W-1:0] cfg_data;

    periodic_task_release_scheduler_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Scheduler state as the testbench believes it to be.
    logic                            sched_enable;
    logic [ptrs_pkg::TASKS_W-1:0]    sched_tasks;
    logic [ptrs_pkg::PHASE_W-1:0]    sched_period [4];
    logic [ptrs_pkg::PHASE_W-1:0]    sched_phase [4];
    logic                            sched_running [4];
    logic [ptrs_pkg::MISS_W-1:0]     sched_misses [4];
    logic [ptrs_pkg::EXEC_W-1:0]     sched_min [4];
    logic [ptrs_pkg::EXEC_W-1:0]     sched_max [4];
    logic [ptrs_pkg::TOTAL_W-1:0]    sched_total [4];
    logic [ptrs_pkg::COUNT_W-1:0]    sched_count [4];

    sched_result_t pending_results [$];
    int            error_count = 0;

    // Traffic shaping knobs shared by the sender, the receiver and the tests.
    bit tx_idle_on = 1'b1;
    bit rx_stall_on = 1'b1;
    int tx_burst_left = 0;
    int rx_hold_cycles = 0;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #30_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Receiver: alternating ready and stall runs, or a long hold when a test asks for one.
    initial begin : receiver
        bit rx_phase_ready;
        int rx_run;
        rx_phase_ready = 1'b0;
        rx_run = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (!rx_stall_on) begin
                m_tready <= 1'b1;
            end else begin
                if (rx_run == 0) begin
                    rx_phase_ready = !rx_phase_ready;
                    rx_run = rx_phase_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                rx_run--;
                m_tready <= rx_phase_ready;
            end
        end
    end

    // Reset state of the scheduler.
    task automatic reset_schedule();
        sched_enable = 1'b0;
        sched_tasks = ptrs_pkg::TASKS_RESET;
        for (int i = 0; i < 4; i++) begin
            sched_period[i] = ptrs_pkg::PERIOD_RESET;
            sched_phase[i] = '0;
            sched_running[i] = 1'b0;
            sched_misses[i] = '0;
            sched_min[i] = '1;
            sched_max[i] = '0;
            sched_total[i] = '0;
            sched_count[i] = '0;
        end
    endtask

    // Applies one request to the tracked state and returns the result it causes.
    function automatic sched_result_t schedule_step(ptrs_pkg::opcode_t op,
                                                    logic [ptrs_pkg::IDX_W-1:0] idx,
                                                    logic [ptrs_pkg::EXEC_W-1:0] et);
        sched_result_t res;
        int active;
        logic [ptrs_pkg::PHASE_W:0] next_phase;
        logic [ptrs_pkg::PHASE_W-1:0] per;
        logic [ptrs_pkg::TOTAL_W:0] sum;
        res = '0;
        case (op)
            ptrs_pkg::OP_TICK: begin
                if (sched_enable) begin
                    active = (sched_tasks > 4) ? 4 : int'(sched_tasks);
                    for (int i = 0; i < active; i++) begin
                        per = (sched_period[i] == 0) ? 16'd1 : sched_period[i];
                        next_phase = {1'b0, sched_phase[i]} + (ptrs_pkg::PHASE_W + 1)'(1);
                        if (next_phase >= {1'b0, per}) begin
                            next_phase = '0;
                            if (sched_running[i]) begin
                                if (sched_misses[i] != '1)
                                    sched_misses[i]++;
                                res.miss_mask[i] = 1'b1;
                            end else begin
                                res.release_mask[i] = 1'b1;
                            end
                        end
                        sched_phase[i] = next_phase[ptrs_pkg::PHASE_W-1:0];
                    end
                end
            end
            ptrs_pkg::OP_START: begin
                sched_running[idx] = 1'b1;
            end
            ptrs_pkg::OP_FINISH: begin
                sched_running[idx] = 1'b0;
                if (et < sched_min[idx])
                    sched_min[idx] = et;
                if (et > sched_max[idx])
                    sched_max[idx] = et;
                sum = {1'b0, sched_total[idx]} + (ptrs_pkg::TOTAL_W + 1)'(et);
                sched_total[idx] = sum[ptrs_pkg::TOTAL_W] ? '1 : sum[ptrs_pkg::TOTAL_W-1:0];
                if (sched_count[idx] != '1)
                    sched_count[idx]++;
            end
            default: begin
            end
        endcase
        res.running = sched_running[idx];
        res.miss_count = sched_misses[idx];
        res.min_exec = sched_min[idx];
        res.max_exec = sched_max[idx];
        res.total_exec = sched_total[idx];
        res.exec_count = sched_count[idx];
        return res;
    endfunction

    // Sends one request, with bursts and gaps when sender idling is on.
    task automatic push_event(ptrs_pkg::opcode_t op, logic [ptrs_pkg::IDX_W-1:0] idx,
                              logic [ptrs_pkg::EXEC_W-1:0] et);
        int gap;
        if (tx_idle_on && tx_burst_left == 0) begin
            gap = $urandom_range(1, 8);
            tx_burst_left = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= ptrs_pkg::S_TUSER_W'(op);
        s_tdata <= ptrs_pkg::S_TDATA_W'({et, idx});
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(schedule_step(op, idx, et));
    endtask

    // Lowers the request valid and waits until every result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes one configuration register while the block is idle.
    task automatic write_reg(logic [ptrs_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptrs_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ptrs_pkg::CFG_ENABLE: sched_enable = value[0];
            ptrs_pkg::CFG_TASKS:  sched_tasks = value[ptrs_pkg::TASKS_W-1:0];
            default: begin
                if (idx >= ptrs_pkg::CFG_PERIOD0 && idx <= ptrs_pkg::CFG_PERIOD0 + 3'd3)
                    sched_period[idx - ptrs_pkg::CFG_PERIOD0] = value;
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_periods(logic [15:0] p0, logic [15:0] p1, logic [15:0] p2,
                                 logic [15:0] p3);
        write_reg(ptrs_pkg::CFG_PERIOD0, p0);
        write_reg(ptrs_pkg::CFG_PERIOD0 + 3'd1, p1);
        write_reg(ptrs_pkg::CFG_PERIOD0 + 3'd2, p2);
        write_reg(ptrs_pkg::CFG_PERIOD0 + 3'd3, p3);
    endtask

    // Field-by-field compare of one result.
    function automatic void check_field(string name, logic [ptrs_pkg::TOTAL_W-1:0] want,
                                        logic [ptrs_pkg::TOTAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result checker.
    always @(posedge aclk) begin : result_check
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sched_result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding, actual %0h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("release_mask", want.release_mask, got.release_mask);
                check_field("miss_mask", want.miss_mask, got.miss_mask);
                check_field("sel_running", want.running, got.running);
                check_field("sel_miss_count", want.miss_count, got.miss_count);
                check_field("sel_min_exec", want.min_exec, got.min_exec);
                check_field("sel_max_exec", want.max_exec, got.max_exec);
                check_field("sel_total_exec", want.total_exec, got.total_exec);
                check_field("sel_exec_count", want.exec_count, got.exec_count);
            end
        end
    end

    // Readout after reset, and ticks while the sequencer is still disabled.
    task automatic test_reset_readout();
        for (int i = 0; i < 4; i++)
            push_event(ptrs_pkg::OP_NONE, ptrs_pkg::IDX_W'(i), 32'hFFFF_FFFF);
        push_event(ptrs_pkg::OP_TICK, 2'd0, 32'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd3, 32'd0);
        drain();
    endtask

    // Start, finish, misses and releases with short periods, including period zero.
    task automatic test_task_events();
        write_reg(ptrs_pkg::CFG_ENABLE, 16'd1);
        write_reg(ptrs_pkg::CFG_TASKS, 16'd4);
        write_periods(16'd1, 16'd2, 16'd3, 16'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd0, 32'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd1, 32'd0);
        push_event(ptrs_pkg::OP_START, 2'd1, 32'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd1, 32'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd1, 32'd0);
        push_event(ptrs_pkg::OP_FINISH, 2'd1, 32'd0);
        push_event(ptrs_pkg::OP_FINISH, 2'd1, 32'hFFFF_FFFF);
        // Finish without a start still records the time.
        push_event(ptrs_pkg::OP_FINISH, 2'd2, 32'h0001_2345);
        push_event(ptrs_pkg::OP_START, 2'd0, 32'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd0, 32'd0);
        push_event(ptrs_pkg::OP_NONE, 2'd0, 32'hA5A5_A5A5);
        push_event(ptrs_pkg::OP_START, 2'd3, 32'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd3, 32'd0);
        push_event(ptrs_pkg::OP_FINISH, 2'd3, 32'h8000_0000);
        drain();
    endtask

    // Task counts of zero, above the slot count, and one; events on unused slots.
    task automatic test_task_count();
        write_reg(ptrs_pkg::CFG_TASKS, 16'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd0, 32'd0);
        drain();
        write_reg(ptrs_pkg::CFG_TASKS, 16'd7);
        push_event(ptrs_pkg::OP_TICK, 2'd2, 32'd0);
        push_event(ptrs_pkg::OP_TICK, 2'd3, 32'd0);
        drain();
        write_reg(ptrs_pkg::CFG_TASKS, 16'd1);
        push_event(ptrs_pkg::OP_TICK, 2'd3, 32'd0);
        push_event(ptrs_pkg::OP_START, 2'd3, 32'd0);
        push_event(ptrs_pkg::OP_FINISH, 2'd3, 32'd7);
        drain();
    endtask

    // A period lowered below the current phase wraps on the next tick.
    task automatic test_period_drop();
        write_reg(ptrs_pkg::CFG_TASKS, 16'd4);
        write_reg(ptrs_pkg::CFG_PERIOD0 + 3'd2, 16'd50);
        repeat (6) push_event(ptrs_pkg::OP_TICK, 2'd2, 32'd0);
        drain();
        write_reg(ptrs_pkg::CFG_PERIOD0 + 3'd2, 16'd3);
        push_event(ptrs_pkg::OP_TICK, 2'd2, 32'd0);
        drain();
    endtask

    // Back-to-back misses and maximal execution times with no idling on either side.
    task automatic test_heavy_load();
        tx_idle_on = 1'b0;
        rx_stall_on = 1'b0;
        write_reg(ptrs_pkg::CFG_ENABLE, 16'd1);
        write_reg(ptrs_pkg::CFG_TASKS, 16'd1);
        write_reg(ptrs_pkg::CFG_PERIOD0, 16'd1);
        push_event(ptrs_pkg::OP_START, 2'd0, 32'd0);
        for (int i = 0; i < 20; i++) begin
            push_event(ptrs_pkg::OP_TICK, 2'd0, 32'd0);
            push_event(ptrs_pkg::OP_FINISH, 2'd1, 32'hFFFF_FFFF);
        end
        push_event(ptrs_pkg::OP_FINISH, 2'd1, 32'd0);
        push_event(ptrs_pkg::OP_NONE, 2'd0, 32'd0);
        drain();
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // One random request: ticks most often, with start and finish events and some no-ops.
    task automatic push_random_event();
        int pick;
        logic [ptrs_pkg::EXEC_W-1:0] et;
        ptrs_pkg::opcode_t op;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = ptrs_pkg::OP_TICK;
        else if (pick < 68)
            op = ptrs_pkg::OP_START;
        else if (pick < 92)
            op = ptrs_pkg::OP_FINISH;
        else
            op = ptrs_pkg::OP_NONE;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            et = '0;
        else if (pick == 1)
            et = '1;
        else if (pick < 6)
            et = $urandom_range(0, 1000);
        else
            et = $urandom;
        push_event(op, ptrs_pkg::IDX_W'($urandom_range(0, 3)), et);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        write_reg(ptrs_pkg::CFG_ENABLE, 16'd1);
        write_reg(ptrs_pkg::CFG_TASKS, 16'd4);
        write_periods(16'd2, 16'd3, 16'd1, 16'd4);
        tx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        repeat (60) push_random_event();
        drain();
        tx_idle_on = 1'b1;
    endtask

    // Random phases, each under its own configuration and traffic shape.
    task automatic test_random();
        logic [15:0] per [4];
        int tasks;
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 4; i++) begin
                case ($urandom_range(0, 5))
                    0: per[i] = 16'd0;
                    1: per[i] = 16'd65535;
                    2: per[i] = 16'($urandom);
                    default: per[i] = 16'($urandom_range(1, 8));
                endcase
            end
            tasks = $urandom_range(0, 7);
            // Keep the extremes in the first two phases.
            if (ph == 0) begin
                per[0] = 16'd65535;
                per[1] = 16'd1;
                tasks = 4;
            end else if (ph == 1) begin
                tasks = 1;
            end
            write_reg(ptrs_pkg::CFG_ENABLE, ($urandom_range(0, 5) != 0) ? 16'd1 : 16'd0);
            write_reg(ptrs_pkg::CFG_TASKS, 16'(tasks));
            write_periods(per[0], per[1], per[2], per[3]);
            tx_idle_on = (ph % 3) != 2;
            rx_stall_on = (ph % 3) != 1;
            repeat (230) push_random_event();
            drain();
        end
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // Main sequence.
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        reset_schedule();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_reset_readout();
        test_task_events();
        test_task_count();
        test_period_drop();
        test_heavy_load();
        test_backpressure();
        test_random();

        drain();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
